// ===== rtl/core/hde_pkg.sv =====
// shared types and constants for the histogram density engine
// no dependencies; every other file refers to this package by scoped names
package hde_pkg;

	// item kinds
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	// register indexes on the apb port (word addresses)
	localparam logic [1:0] REG_BIN_WIDTH     = 2'd0;
	localparam logic [1:0] REG_INV_BIN_WIDTH = 2'd1;
	localparam logic [1:0] REG_BIN_BASE      = 2'd2;

	localparam int ADDR_W = 4;

	// register reset values
	localparam logic [31:0]        RST_BIN_WIDTH     = 32'd1677722;
	localparam logic [31:0]        RST_INV_BIN_WIDTH = 32'd655360;
	localparam logic signed [31:0] RST_BIN_BASE      = -32'sd2048;

	// quotient bits of the density divider
	localparam int DIV_STEPS = 32;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] sample;
		logic [11:0]        read_slot;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [63:0] bin_centre;
		logic [31:0]        bin_count;
		logic [31:0]        density;
		logic [31:0]        total_count;
		logic [11:0]        lowest_slot;
		logic [11:0]        highest_slot;
	} result_t;

	typedef struct packed {
		logic [31:0]        bin_width;
		logic [31:0]        inv_bin_width;
		logic signed [31:0] bin_base;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mul;
		logic index;
		logic window;
		logic centre;
		logic update;
		logic den_lo;
		logic den_hi;
		logic div_init;
		logic div_step;
		logic clr_step;
		logic clr_totals;
		logic load_result;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
	} stat_t;

endpackage

// ===== rtl/core/histogram_density_engine.sv =====
// top level of the histogram density engine: apb registers, controller, datapath
// depends on hde_pkg, hde_regs, hde_ctrl, hde_dp
//
// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------
// item      | start, busy, item                       | taken when start & !busy
// result    | done, result                            | one-cycle strobe, no stall
// config    | psel, penable, pwrite, paddr, pwdata... | apb, pready tied high
//
// an add or read item steps through the mul, index, window, centre, update,
// den_lo, den_hi, div_init, div (32-step restoring density divider) and result
// states; a clear item walks the count store one slot a cycle, then strobes done
// after reset the same clearing pass runs over every slot with busy high
// busy drops with the done strobe, so the next item can be taken during it
module histogram_density_engine #(
	parameter int NUM_BINS   = 4096,
	parameter int COUNT_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hde_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       start,
	output logic                       busy,
	input  hde_pkg::item_t             item,
	output logic                       done,
	output hde_pkg::result_t           result
);

	hde_pkg::cfg_t  cfg;
	hde_pkg::cmd_t  cmd;
	hde_pkg::stat_t stat;

	assign pready = 1'b1;

	// configuration registers
	hde_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer
	hde_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// arithmetic and count store
	hde_dp #(
		.NUM_BINS   (NUM_BINS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cfg    (cfg),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule

// ===== rtl/core/hde_regs.sv =====
// apb configuration registers: bin width, reciprocal bin width, bin base
// depends on hde_pkg
module hde_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [hde_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output hde_pkg::cfg_t             cfg
);

	logic        wr_en;
	logic [1:0]  reg_idx;
	hde_pkg::cfg_t cfg_q;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_width     <= hde_pkg::RST_BIN_WIDTH;
			cfg_q.inv_bin_width <= hde_pkg::RST_INV_BIN_WIDTH;
			cfg_q.bin_base      <= hde_pkg::RST_BIN_BASE;
		end else if (wr_en) begin
			unique case (reg_idx)
				hde_pkg::REG_BIN_WIDTH:     cfg_q.bin_width     <= pwdata;
				hde_pkg::REG_INV_BIN_WIDTH: cfg_q.inv_bin_width <= pwdata;
				hde_pkg::REG_BIN_BASE:      cfg_q.bin_base      <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			hde_pkg::REG_BIN_WIDTH:     prdata = cfg_q.bin_width;
			hde_pkg::REG_INV_BIN_WIDTH: prdata = cfg_q.inv_bin_width;
			hde_pkg::REG_BIN_BASE:      prdata = cfg_q.bin_base;
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/hde_ctrl.sv =====
// controller for the histogram density engine: sequences binning, update,
// density division and clearing passes; depends on hde_pkg
module hde_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     kind,
	input  hde_pkg::stat_t stat,
	output hde_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	localparam int CNT_W = $clog2(hde_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hde_pkg::DIV_STEPS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_INDEX,
		ST_WINDOW,
		ST_CENTRE,
		ST_UPDATE,
		ST_DEN_LO,
		ST_DEN_HI,
		ST_DIV_INIT,
		ST_DIV,
		ST_RESULT
	} state_t;

	state_t           state_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             clr_item_q;

	assign busy = busy_q;
	assign done = done_q;

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			busy_q     <= 1'b1;
			done_q     <= 1'b0;
			div_cnt_q  <= '0;
			clr_item_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						unique case (kind)
							hde_pkg::KIND_ADD,
							hde_pkg::KIND_READ: state_q <= ST_MUL;
							hde_pkg::KIND_CLEAR: begin
								state_q    <= ST_CLEAR;
								clr_item_q <= 1'b1;
							end
							default: state_q <= ST_RESULT;
						endcase
					end
				end
				ST_CLEAR: begin
					if (stat.clr_last) begin
						clr_item_q <= 1'b0;
						if (clr_item_q) begin
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_IDLE;
							busy_q  <= 1'b0;
						end
					end
				end
				ST_MUL:    state_q <= ST_INDEX;
				ST_INDEX:  state_q <= ST_WINDOW;
				ST_WINDOW: state_q <= ST_CENTRE;
				ST_CENTRE: state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_DEN_LO;
				ST_DEN_LO: state_q <= ST_DEN_HI;
				ST_DEN_HI: state_q <= ST_DIV_INIT;
				ST_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_LAST) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == ST_IDLE) && start;
		cmd.mul         = (state_q == ST_MUL);
		cmd.index       = (state_q == ST_INDEX);
		cmd.window      = (state_q == ST_WINDOW);
		cmd.centre      = (state_q == ST_CENTRE);
		cmd.update      = (state_q == ST_UPDATE);
		cmd.den_lo      = (state_q == ST_DEN_LO);
		cmd.den_hi      = (state_q == ST_DEN_HI);
		cmd.div_init    = (state_q == ST_DIV_INIT);
		cmd.div_step    = (state_q == ST_DIV);
		cmd.clr_step    = (state_q == ST_CLEAR);
		cmd.clr_totals  = (state_q == ST_CLEAR) && stat.clr_last;
		cmd.load_result = (state_q == ST_RESULT);
	end

endmodule

// ===== rtl/core/hde_dp.sv =====
// datapath of the histogram density engine: binning multiply, window check,
// bin count store, centre product, denominator product and restoring divider
// depends on hde_pkg
module hde_dp #(
	parameter int NUM_BINS   = 4096,
	parameter int COUNT_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hde_pkg::cmd_t    cmd,
	input  hde_pkg::cfg_t    cfg,
	input  hde_pkg::item_t   item,
	output hde_pkg::stat_t   stat,
	output hde_pkg::result_t result
);

	localparam int SLOT_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int DEN_W  = COUNT_BITS + 32;
	localparam logic [SLOT_W-1:0]     SLOT_LAST = SLOT_W'(NUM_BINS - 1);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [33:0]           NUM_BINS_X = 34'(NUM_BINS);
	localparam logic [64:0] POS_LIM = {2'b00, {63{1'b1}}};
	localparam logic [64:0] NEG_LIM = {2'b01, 63'd0};
	localparam logic [63:0] CENTRE_MAX = {1'b0, {63{1'b1}}};
	localparam logic [63:0] CENTRE_MIN = {1'b1, 63'd0};

	// count store
	logic [COUNT_BITS-1:0] bins_mem [NUM_BINS];
	logic                  mem_we;
	logic [SLOT_W-1:0]     mem_waddr;
	logic [COUNT_BITS-1:0] mem_wdata;
	logic [COUNT_BITS-1:0] rdata_q;

	// item and intermediate registers
	logic [1:0]            kind_q;
	logic                  sneg_q;
	logic [31:0]           smag_q;
	logic [11:0]           rslot_q;
	logic [31:0]           q_q;
	logic [33:0]           k_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  inwin_q;
	logic                  kneg_q;
	logic [32:0]           kmag_q;
	logic [64:0]           cprod_q;
	logic [63:0]           centre_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [DEN_W-1:0]      den_q;
	logic [DEN_W-1:0]      rem_q;
	logic [31:0]           quot_q;
	logic                  sat_q;
	hde_pkg::result_t      result_q;

	// histogram state
	logic [COUNT_BITS-1:0] total_q;
	logic [SLOT_W-1:0]     min_q;
	logic [SLOT_W-1:0]     max_q;
	logic [SLOT_W-1:0]     clr_ptr_q;

	// combinational helpers
	logic [31:0]           smag_in;
	logic [63:0]           bin_prod;
	logic [33:0]           base_x;
	logic [33:0]           rslot_x;
	logic [33:0]           q_x;
	logic [33:0]           k_next;
	logic [33:0]           k_neg;
	logic [33:0]           slot_w;
	logic                  inwin_w;
	logic [64:0]           cent_prod;
	logic [63:0]           centre_sat;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  add_hit;
	logic [47:0]           total_x;
	logic [55:0]           den_part;
	logic [79:0]           den_hi_term;
	logic [DEN_W-1:0]      num_hi;
	logic [DEN_W:0]        rem_sh;
	logic                  rem_ge;
	logic                  want_dens;
	logic                  is_bin_kind;
	logic [79:0]           count_x;
	logic [79:0]           total_w;
	logic [15:0]           min_x;
	logic [15:0]           max_x;
	hde_pkg::result_t      res_next;

	assign stat.clr_last = (clr_ptr_q == SLOT_LAST);
	assign result        = result_q;

	// sample magnitude taken at capture
	assign smag_in = item.sample[31] ? (~item.sample + 32'd1) : item.sample;

	// binning product, bin index and slot
	assign bin_prod = {32'd0, smag_q} * {32'd0, cfg.inv_bin_width};
	assign base_x   = {{2{cfg.bin_base[31]}}, cfg.bin_base};
	assign rslot_x  = {22'd0, rslot_q};
	assign q_x      = {2'd0, q_q};
	assign k_next   = (kind_q == hde_pkg::KIND_READ) ? (base_x + rslot_x)
	                : (sneg_q ? (34'd0 - q_x) : q_x);
	assign k_neg    = 34'd0 - k_q;
	assign slot_w   = (kind_q == hde_pkg::KIND_READ) ? rslot_x : (k_q - base_x);
	assign inwin_w  = !slot_w[33] && (slot_w < NUM_BINS_X);

	// centre product and its saturation
	assign cent_prod = {32'd0, kmag_q} * {33'd0, cfg.bin_width};
	always_comb begin
		if (kneg_q) begin
			centre_sat = (cprod_q > NEG_LIM) ? CENTRE_MIN : (64'd0 - cprod_q[63:0]);
		end else begin
			centre_sat = (cprod_q > POS_LIM) ? CENTRE_MAX : cprod_q[63:0];
		end
	end

	// saturating count update
	assign cnt_inc = (rdata_q == COUNT_MAX) ? rdata_q : (rdata_q + 1'b1);
	assign add_hit = (kind_q == hde_pkg::KIND_ADD) && inwin_q;

	// store write port: clearing pass or count update
	assign mem_we    = cmd.clr_step || (cmd.update && add_hit);
	assign mem_waddr = cmd.clr_step ? clr_ptr_q : slot_q;
	assign mem_wdata = cmd.clr_step ? '0 : cnt_inc;

	// denominator total * dx in two partial products
	assign total_x     = 48'(total_q);
	assign den_part    = 56'(cmd.den_hi ? total_x[47:24] : total_x[23:0])
	                   * 56'(cfg.bin_width);
	assign den_hi_term = {den_part, 24'd0};

	// divider: count * 2^40 / den, the low numerator bits are all zero
	assign num_hi = DEN_W'({count_q, 8'd0});
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.centre && inwin_q) begin
			rdata_q <= bins_mem[slot_q];
		end
	end

	// item and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= item.kind;
			sneg_q  <= item.sample[31];
			smag_q  <= smag_in;
			rslot_q <= item.read_slot;
		end
		if (cmd.mul) begin
			q_q <= bin_prod[63:32];
		end
		if (cmd.index) begin
			k_q <= k_next;
		end
		if (cmd.window) begin
			slot_q  <= slot_w[SLOT_W-1:0];
			inwin_q <= inwin_w;
			kneg_q  <= k_q[33];
			kmag_q  <= k_q[33] ? k_neg[32:0] : k_q[32:0];
		end
		if (cmd.centre) begin
			cprod_q <= cent_prod;
		end
		if (cmd.update) begin
			centre_q <= centre_sat;
			count_q  <= add_hit ? cnt_inc : rdata_q;
		end
		if (cmd.den_lo) begin
			den_q <= DEN_W'(den_part);
		end
		if (cmd.den_hi) begin
			den_q <= den_q + DEN_W'(den_hi_term);
		end
		if (cmd.div_init) begin
			sat_q  <= (num_hi >= den_q);
			rem_q  <= num_hi;
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quot_q <= {quot_q[30:0], rem_ge};
		end
		if (cmd.load_result) begin
			result_q <= res_next;
		end
	end

	// running total, lowest and highest slot, clearing pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			min_q     <= SLOT_LAST;
			max_q     <= '0;
			clr_ptr_q <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_ptr_q <= (clr_ptr_q == SLOT_LAST) ? '0 : (clr_ptr_q + 1'b1);
			end
			if (cmd.clr_totals) begin
				total_q <= '0;
				min_q   <= SLOT_LAST;
				max_q   <= '0;
			end else if (cmd.update && add_hit) begin
				if (total_q != COUNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
				if (slot_q < min_q) begin
					min_q <= slot_q;
				end
				if (slot_q > max_q) begin
					max_q <= slot_q;
				end
			end
		end
	end

	// result assembly
	assign is_bin_kind = (kind_q == hde_pkg::KIND_ADD) || (kind_q == hde_pkg::KIND_READ);
	assign want_dens   = inwin_q && (count_q != '0) && ((kind_q == hde_pkg::KIND_ADD)
	                   || ((kind_q == hde_pkg::KIND_READ) && (total_q != '0)));
	assign count_x     = 80'(count_q);
	assign total_w     = 80'(total_q);
	assign min_x       = 16'(min_q);
	assign max_x       = 16'(max_q);

	always_comb begin
		res_next              = '0;
		res_next.bin_centre   = is_bin_kind ? centre_q : '0;
		res_next.bin_count    = (is_bin_kind && inwin_q) ? count_x[31:0] : '0;
		res_next.density      = want_dens ? (sat_q ? '1 : quot_q) : '0;
		res_next.total_count  = total_w[31:0];
		res_next.lowest_slot  = min_x[11:0];
		res_next.highest_slot = max_x[11:0];
		unique case (kind_q)
			hde_pkg::KIND_ADD: begin
				res_next.status = inwin_q ? hde_pkg::STATUS_OK : hde_pkg::STATUS_OUTSIDE;
			end
			hde_pkg::KIND_READ: begin
				if (!inwin_q) begin
					res_next.status = hde_pkg::STATUS_OUTSIDE;
				end else if (total_q == '0) begin
					res_next.status = hde_pkg::STATUS_EMPTY;
				end else begin
					res_next.status = hde_pkg::STATUS_OK;
				end
			end
			default: res_next.status = hde_pkg::STATUS_OK;
		endcase
	end

endmodule

// ===== rtl/core/hde_checker.sv =====
// port-level checks for the histogram density engine, bound to the top level
// depends on hde_pkg and histogram_density_engine
module hde_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input hde_pkg::result_t result
);

	// an accepted item keeps the engine busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("engine not busy after accepting an item");

	// a result only follows a busy period and frees the engine
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) && !busy))
		else $error("result strobe without a preceding busy period");

	// any non-ok status carries zero density
	a_status_density: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != hde_pkg::STATUS_OK)) |-> (result.density == 32'd0))
		else $error("density reported with a non-ok status");

	// empty status only while nothing is counted
	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == hde_pkg::STATUS_EMPTY)) |-> (result.total_count == 32'd0))
		else $error("empty status with a nonzero total");

endmodule

bind histogram_density_engine hde_checker u_hde_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for histogram_density_engine: item driver, result monitor, predictor
// depends on hde_pkg and the histogram_density_engine rtl
module tb_top;

	localparam int NUM_BINS       = 4096;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 20000;

	// the one kind the package leaves unnamed
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic signed [127:0] CENTRE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] CENTRE_MIN = -128'sh8000_0000_0000_0000;

	logic                       clk     = 1'b0;
	logic                       arst_n  = 1'b0;
	logic                       psel    = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite  = 1'b0;
	logic [hde_pkg::ADDR_W-1:0] paddr   = '0;
	logic [31:0]                pwdata  = '0;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       start   = 1'b0;
	logic                       busy;
	hde_pkg::item_t             item    = '0;
	logic                       done;
	hde_pkg::result_t           result;

	// predictor copy of the registers and the count store
	hde_pkg::cfg_t cfg_now = '{hde_pkg::RST_BIN_WIDTH, hde_pkg::RST_INV_BIN_WIDTH,
		hde_pkg::RST_BIN_BASE};
	logic [31:0] slot_counts [NUM_BINS] = '{default: '0};
	logic [31:0] samples_total = '0;
	logic [11:0] low_slot      = 12'(NUM_BINS - 1);
	logic [11:0] high_slot     = '0;

	hde_pkg::item_t   pending_items[$];
	hde_pkg::result_t expected_results[$];
	hde_pkg::result_t want;
	int      mismatches  = 0;
	int      idle_cycles = 0;
	int      gap_left    = 0;
	int      burst_left  = 0;

	histogram_density_engine dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// append an item to the pending queue
	task automatic queue_item(input hde_pkg::item_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	// append a predicted result to the expectation queue
	task automatic queue_result(input hde_pkg::result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	// compare one field, print and count on a difference
	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] exp_val);
		if (got !== exp_val) begin
			$display("%0t mismatch on %s: got %h, wanted %h", $time, name, got, exp_val);
			mismatches++;
		end
	endtask

	// bin centre k*dx in q24, saturating to 64 bits signed
	function automatic logic signed [63:0] centre_q24(input longint k);
		logic signed [127:0] prod, w;
		prod = k;
		w    = {96'd0, cfg_now.bin_width};
		prod = prod * w;
		if (prod > CENTRE_MAX) return 64'h7FFF_FFFF_FFFF_FFFF;
		if (prod < CENTRE_MIN) return 64'h8000_0000_0000_0000;
		return prod[63:0];
	endfunction

	// count / (total * dx) in q16, saturating
	function automatic logic [31:0] density_q16(input logic [31:0] cnt);
		logic [127:0] num, den, quo;
		if (cnt == 0) return '0;
		num = 128'(cnt) << 40;
		den = 128'(samples_total) * 128'(cfg_now.bin_width);
		if (den == 0) return 32'hFFFF_FFFF;
		quo = num / den;
		return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
	endfunction

	// apply one accepted item to the predicted store, return its result
	function automatic hde_pkg::result_t bin_item(input hde_pkg::item_t it);
		hde_pkg::result_t r;
		longint  base, sv, k, slot;
		logic [63:0] mag, prod;
		r    = '0;
		base = cfg_now.bin_base;
		case (it.kind)
			hde_pkg::KIND_ADD: begin
				sv   = it.sample;
				mag  = (sv < 0) ? -sv : sv;
				prod = mag * 64'(cfg_now.inv_bin_width);
				k    = prod >> 32;
				if (sv < 0)
					k = -k;
				slot = k - base;
				r.bin_centre = centre_q24(k);
				if (slot < 0 || slot >= NUM_BINS) begin
					r.status = hde_pkg::STATUS_OUTSIDE;
				end else begin
					if (slot_counts[slot] != 32'hFFFF_FFFF)
						slot_counts[slot]++;
					if (samples_total != 32'hFFFF_FFFF)
						samples_total++;
					if (slot[11:0] < low_slot)
						low_slot = slot[11:0];
					if (slot[11:0] > high_slot)
						high_slot = slot[11:0];
					r.bin_count = slot_counts[slot];
					r.density   = density_q16(slot_counts[slot]);
				end
			end
			hde_pkg::KIND_READ: begin
				r.bin_centre = centre_q24(base + longint'(it.read_slot));
				r.bin_count  = slot_counts[it.read_slot];
				if (samples_total == 0)
					r.status = hde_pkg::STATUS_EMPTY;
				else
					r.density = density_q16(slot_counts[it.read_slot]);
			end
			hde_pkg::KIND_CLEAR: begin
				foreach (slot_counts[i])
					slot_counts[i] = '0;
				samples_total = '0;
				low_slot      = 12'(NUM_BINS - 1);
				high_slot     = '0;
			end
			default: ;
		endcase
		r.total_count  = samples_total;
		r.lowest_slot  = low_slot;
		r.highest_slot = high_slot;
		return r;
	endfunction

	// a sample that lands in slot t under the current registers, clamped to 32 bits
	function automatic logic signed [31:0] sample_in_slot(input int t);
		longint       k;
		logic [127:0] mag, lo, hi, pick;
		logic [31:0]  inv;
		k   = longint'(cfg_now.bin_base) + t;
		inv = cfg_now.inv_bin_width;
		mag = '0;
		mag[63:0] = (k < 0) ? -k : k;
		lo   = ((mag << 32) + inv - 1) / inv;
		hi   = (((mag + 1) << 32) + inv - 1) / inv - 1;
		pick = lo + ({$urandom, $urandom} % (hi - lo + 1));
		if (k < 0) begin
			if (pick > 128'h8000_0000)
				pick = 128'h8000_0000;
			return -pick[31:0];
		end
		if (pick > 128'h7FFF_FFFF)
			pick = 128'h7FFF_FFFF;
		return pick[31:0];
	endfunction

	function automatic hde_pkg::item_t make_item(input logic [1:0] kind,
			input logic [31:0] sample, input logic [11:0] slot);
		hde_pkg::item_t it;
		it.kind      = kind;
		it.sample    = sample;
		it.read_slot = slot;
		return it;
	endfunction

	// mostly adds clustered round a hot slot, some noise, reads, spare kinds and clears
	function automatic hde_pkg::item_t random_item(input int hot);
		hde_pkg::item_t it;
		int    pick, t;
		it   = make_item(hde_pkg::KIND_ADD, $urandom, 12'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			if ($urandom_range(0, 4) == 0)
				t = $urandom_range(0, NUM_BINS - 1);
			else
				t = hot + int'($urandom_range(0, 31)) - 16;
			it.sample = sample_in_slot(t);
		end else if (pick < 80) begin
			it.kind = hde_pkg::KIND_ADD;
		end else if (pick < 96) begin
			it.kind = hde_pkg::KIND_READ;
			if ($urandom_range(0, 1) == 0)
				it.read_slot = 12'(hot + int'($urandom_range(0, 31)) - 16);
		end else if (pick < 99) begin
			it.kind = KIND_SPARE;
		end else begin
			it.kind = hde_pkg::KIND_CLEAR;
		end
		return it;
	endfunction

	// apb write: setup then access phase
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			hde_pkg::REG_BIN_WIDTH:     cfg_now.bin_width     = value;
			hde_pkg::REG_INV_BIN_WIDTH: cfg_now.inv_bin_width = value;
			hde_pkg::REG_BIN_BASE:      cfg_now.bin_base      = value;
			default: ;
		endcase
	endtask

	// hold off until every item is taken and every result is back
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [31:0] bw, input logic [31:0] inv,
			input logic [31:0] base, input int count);
		int hot;
		hot = 0;
		apb_write(hde_pkg::REG_BIN_WIDTH, bw);
		apb_write(hde_pkg::REG_INV_BIN_WIDTH, inv);
		apb_write(hde_pkg::REG_BIN_BASE, base);
		for (int i = 0; i < count; i++) begin
			if (i % 64 == 0)
				hot = $urandom_range(0, NUM_BINS - 1);
			queue_item(random_item(hot));
		end
		wait_idle();
	endtask

	// item driver: bursts of items with random gaps, prediction on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			item       <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (start && !busy)
				queue_result(bin_item(item));
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					start <= 1'b1;
					item  <= pending_items.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 16);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: each strobe against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				check_field("done with nothing expected", 64'd1, 64'd0);
			end else begin
				want = expected_results.pop_front();
				check_field("status", result.status, want.status);
				check_field("bin_centre", result.bin_centre, want.bin_centre);
				check_field("bin_count", result.bin_count, want.bin_count);
				check_field("density", result.density, want.density);
				check_field("total_count", result.total_count, want.total_count);
				check_field("lowest_slot", result.lowest_slot, want.lowest_slot);
				check_field("highest_slot", result.highest_slot, want.highest_slot);
			end
		end
	end

	// watchdog on cycles with no item and no result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t no progress for %0d cycles", $time, idle_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed items under reset registers
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'd0));
		queue_item(make_item(KIND_SPARE, $urandom, 12'($urandom)));
		queue_item(make_item(hde_pkg::KIND_ADD, 32'h0, 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, sample_in_slot(0), 12'hFFF));
		queue_item(make_item(hde_pkg::KIND_ADD, sample_in_slot(NUM_BINS - 1), 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, sample_in_slot(NUM_BINS), 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, sample_in_slot(-1), 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, 32'h7FFF_FFFF, 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, 32'h8000_0000, 12'h0));
		queue_item(make_item(hde_pkg::KIND_READ, 32'hFFFF_FFFF, 12'd0));
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'hFFF));
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'd2048));
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'd1234));
		queue_item(make_item(KIND_SPARE, 32'hFFFF_FFFF, 12'hFFF));
		queue_item(make_item(hde_pkg::KIND_CLEAR, 32'h0, 12'h0));
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'd2048));
		queue_item(make_item(hde_pkg::KIND_ADD, 32'h0, 12'h0));
		queue_item(make_item(hde_pkg::KIND_ADD, 32'h1, 12'h0));
		queue_item(make_item(hde_pkg::KIND_READ, 32'h0, 12'd2048));
		wait_idle();

		// register settings, extremes first
		run_phase(hde_pkg::RST_BIN_WIDTH, hde_pkg::RST_INV_BIN_WIDTH,
			hde_pkg::RST_BIN_BASE, 500);
		run_phase(32'hFFFF_FFFF, 32'd1, 32'd0, 150);
		run_phase(32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 200);
		// zero bin width: density saturates on any nonzero count
		run_phase(32'd0, 32'd65536, -32'sd100, 60);
		// top of the index range: centres saturate
		run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 80);
		repeat (4)
			run_phase($urandom_range(1, 32'hFFFF_FFFF), $urandom_range(1 << 10, 1 << 22),
				32'(int'($urandom_range(0, 400000)) - 200000), 190);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
